FILE: hdl/lsbx_pkg.sv
`default_nettype none

package lsbx_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned POS_W      = 32;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned IN_TDATA_W = 8;
  // out_byte and status packed, padded to whole bytes
  localparam int unsigned OUT_TDATA_W = 16;

  // result queue
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PTR_W = 2;
  localparam int unsigned OUT_CNT_W = 3;

  localparam logic [POS_W-1:0] MIN_FILE_SIZE = 32'd54;
  localparam logic [POS_W-1:0] OFFSET_FIELD  = 32'd10;
  localparam logic [POS_W-1:0] OFFSET_LAST   = 32'd13;
  localparam logic [POS_W-1:0] MIN_OFFSET    = 32'd14;
  localparam logic [3:0]       HDR_LAST_IDX  = 4'd11;

  localparam logic [BYTE_W-1:0] SIG_B = 8'h42;
  localparam logic [BYTE_W-1:0] SIG_M = 8'h4D;

  localparam logic [KIND_W-1:0] KIND_NAME   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DATA   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOFILE  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_CORRUPT = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0]   out_byte;
    logic [KIND_W-1:0]   kind;
    logic [STATUS_W-1:0] status;
    logic                last;
  } result_t;

  // payload magic "ECS1"
  function automatic logic [BYTE_W-1:0] magic_char(input logic [1:0] idx);
    logic [BYTE_W-1:0] c;
    case (idx)
      2'd0:    c = 8'h45;
      2'd1:    c = 8'h43;
      2'd2:    c = 8'h53;
      default: c = 8'h31;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/lsb_stego_bmp_extractor_core.sv
// Results: a result word is written into the registered result queue as its input word is accepted.
// Throughput: one input word per cycle while the result queue has room; the end-of-file word yields up to two result
//   words (a recovered byte and the status), which drain through a four-entry result queue.
// in_tready drops while the result queue has fewer than two free entries.
// Reset: synchronous, active low; clears the parse state and empties the result queue.
`default_nettype none

module lsb_stego_bmp_extractor_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [lsbx_pkg::IN_TDATA_W-1:0]   in_tdata,   // [7:0] carrier_byte
  input  wire logic                              in_tlast,   // end_of_file
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [lsbx_pkg::OUT_TDATA_W-1:0]       out_tdata,  // [7:0] out_byte, [9:8] status
  output logic [lsbx_pkg::KIND_W-1:0]            out_tuser,  // [1:0] kind
  output logic                                   out_tlast   // last
);

  import lsbx_pkg::*;

  typedef enum logic [2:0] {
    PH_IMAGE,
    PH_HEADER,
    PH_NAME,
    PH_DATA,
    PH_DONE,
    PH_FAILED
  } phase_t;

  // parse state
  phase_t              phase_r,    phase_nxt;
  logic [POS_W-1:0]    pos_r,      pos_nxt;
  logic [POS_W-1:0]    poff_r,     poff_nxt;
  logic [BYTE_W-1:0]   acc_r,      acc_nxt;
  logic [2:0]          bcnt_r,     bcnt_nxt;
  logic [3:0]          hidx_r,     hidx_nxt;
  logic [POS_W-1:0]    nlen_r,     nlen_nxt;
  logic [POS_W-1:0]    dlen_r,     dlen_nxt;
  logic [POS_W-1:0]    rem_r,      rem_nxt;
  logic [STATUS_W-1:0] err_r,      err_nxt;

  // result queue
  result_t              q_mem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [OUT_CNT_W-1:0] cnt_r,    cnt_nxt;

  logic                 in_fire;
  logic                 out_fire;
  logic                 emit_byte;
  logic                 emit_stat;
  result_t              byte_res;
  result_t              stat_res;
  logic [OUT_PTR_W-1:0] stat_ptr;

  assign in_fire  = in_tvalid & in_tready;
  assign out_fire = out_tvalid & out_tready;

  // accept only while two result slots are free, so a word never blocks mid-step
  assign in_tready  = (cnt_r <= OUT_CNT_W'(OUT_DEPTH - 2));
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = {{(OUT_TDATA_W - BYTE_W - STATUS_W){1'b0}},
                       q_mem[rd_ptr_r].status, q_mem[rd_ptr_r].out_byte};
  assign out_tuser  = q_mem[rd_ptr_r].kind;
  assign out_tlast  = q_mem[rd_ptr_r].last;

  // one file byte per step
  always_comb begin
    logic [BYTE_W-1:0]   b;
    logic [1:0]          osel;
    logic [BYTE_W-1:0]   v;
    logic [STATUS_W-1:0] st;
    logic [POS_W-1:0]    rem_dec;

    b        = in_tdata[BYTE_W-1:0];
    osel     = pos_r[1:0] - 2'd2;
    v        = '0;
    st       = ST_OK;
    rem_dec  = rem_r - POS_W'(1);

    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    poff_nxt  = poff_r;
    acc_nxt   = acc_r;
    bcnt_nxt  = bcnt_r;
    hidx_nxt  = hidx_r;
    nlen_nxt  = nlen_r;
    dlen_nxt  = dlen_r;
    rem_nxt   = rem_r;
    err_nxt   = err_r;
    emit_byte = 1'b0;
    emit_stat = 1'b0;
    byte_res  = '0;
    stat_res  = '0;

    if (in_fire) begin
      // saturate the byte position
      if (pos_r != '1) begin
        pos_nxt = pos_r + POS_W'(1);
      end

      // image header: signature and little-endian pixel offset
      if (phase_nxt == PH_IMAGE) begin
        if ((pos_r == '0 && b != SIG_B) || (pos_r == POS_W'(1) && b != SIG_M)) begin
          if (err_nxt == ST_OK) begin
            err_nxt = ST_INVALID;
          end
          phase_nxt = PH_FAILED;
        end
        if (pos_r >= OFFSET_FIELD && pos_r <= OFFSET_LAST) begin
          poff_nxt = poff_nxt | ({{(POS_W-BYTE_W){1'b0}}, b} << {osel, 3'b000});
        end
        if (pos_r == OFFSET_LAST && poff_nxt < MIN_OFFSET) begin
          if (err_nxt == ST_OK) begin
            err_nxt = ST_INVALID;
          end
          phase_nxt = PH_FAILED;
        end
        if (phase_nxt == PH_IMAGE && pos_r >= MIN_OFFSET && pos_r >= poff_nxt) begin
          phase_nxt = PH_HEADER;
        end
      end

      // pixel area: gather low bits, msb first
      if (phase_nxt == PH_HEADER || phase_nxt == PH_NAME || phase_nxt == PH_DATA) begin
        acc_nxt = {acc_r[BYTE_W-2:0], b[0]};
        if (bcnt_r != 3'd7) begin
          bcnt_nxt = bcnt_r + 3'd1;
        end else begin
          v        = acc_nxt;
          bcnt_nxt = '0;
          case (phase_nxt)
            PH_HEADER: begin
              if (hidx_r < 4'd4) begin
                if (v != magic_char(hidx_r[1:0])) begin
                  if (err_nxt == ST_OK) begin
                    err_nxt = ST_NOFILE;
                  end
                  phase_nxt = PH_FAILED;
                end
              end else if (hidx_r < 4'd8) begin
                nlen_nxt = nlen_r |
                           ({{(POS_W-BYTE_W){1'b0}}, v} << {hidx_r[1:0], 3'b000});
              end else if (hidx_r <= HDR_LAST_IDX) begin
                dlen_nxt = dlen_r |
                           ({{(POS_W-BYTE_W){1'b0}}, v} << {hidx_r[1:0], 3'b000});
              end
              hidx_nxt = hidx_r + 4'd1;
              if (phase_nxt == PH_HEADER && hidx_r == HDR_LAST_IDX) begin
                if (nlen_nxt == '0 || nlen_nxt[POS_W-1] || dlen_nxt[POS_W-1]) begin
                  if (err_nxt == ST_OK) begin
                    err_nxt = ST_CORRUPT;
                  end
                  phase_nxt = PH_FAILED;
                end else begin
                  rem_nxt   = nlen_nxt;
                  phase_nxt = PH_NAME;
                end
              end
            end
            PH_NAME: begin
              emit_byte         = 1'b1;
              byte_res.out_byte = v;
              byte_res.kind     = KIND_NAME;
              rem_nxt           = rem_dec;
              if (rem_dec == '0) begin
                if (dlen_r == '0) begin
                  phase_nxt = PH_DONE;
                end else begin
                  rem_nxt   = dlen_r;
                  phase_nxt = PH_DATA;
                end
              end
            end
            default: begin
              emit_byte         = 1'b1;
              byte_res.out_byte = v;
              byte_res.kind     = KIND_DATA;
              rem_nxt           = rem_dec;
              if (rem_dec == '0) begin
                phase_nxt = PH_DONE;
              end
            end
          endcase
        end
      end

      // end of file: rank the outcome, then start over for the next file
      if (in_tlast) begin
        if (pos_nxt < MIN_FILE_SIZE || err_nxt == ST_INVALID || poff_nxt >= pos_nxt) begin
          st = ST_INVALID;
        end else if (err_nxt != ST_OK) begin
          st = err_nxt;
        end else if (phase_nxt == PH_DONE) begin
          st = ST_OK;
        end else if (phase_nxt == PH_NAME || phase_nxt == PH_DATA) begin
          st = ST_CORRUPT;
        end else begin
          st = ST_NOFILE;
        end
        emit_stat       = 1'b1;
        stat_res.kind   = KIND_STATUS;
        stat_res.status = st;
        stat_res.last   = 1'b1;

        phase_nxt = PH_IMAGE;
        pos_nxt   = '0;
        poff_nxt  = '0;
        acc_nxt   = '0;
        bcnt_nxt  = '0;
        hidx_nxt  = '0;
        nlen_nxt  = '0;
        dlen_nxt  = '0;
        rem_nxt   = '0;
        err_nxt   = ST_OK;
      end
    end

    cnt_nxt = cnt_r + OUT_CNT_W'(emit_byte) + OUT_CNT_W'(emit_stat) - OUT_CNT_W'(out_fire);
  end

  // the status lands behind the byte when both come from one word
  assign stat_ptr = emit_byte ? (wr_ptr_r + OUT_PTR_W'(1)) : wr_ptr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IMAGE;
      pos_r    <= '0;
      poff_r   <= '0;
      acc_r    <= '0;
      bcnt_r   <= '0;
      hidx_r   <= '0;
      nlen_r   <= '0;
      dlen_r   <= '0;
      rem_r    <= '0;
      err_r    <= ST_OK;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      poff_r   <= poff_nxt;
      acc_r    <= acc_nxt;
      bcnt_r   <= bcnt_nxt;
      hidx_r   <= hidx_nxt;
      nlen_r   <= nlen_nxt;
      dlen_r   <= dlen_nxt;
      rem_r    <= rem_nxt;
      err_r    <= err_nxt;
      wr_ptr_r <= wr_ptr_r + OUT_PTR_W'(emit_byte) + OUT_PTR_W'(emit_stat);
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + OUT_PTR_W'(1);
      end
      cnt_r    <= cnt_nxt;
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk) begin
    if (emit_byte) begin
      q_mem[wr_ptr_r] <= byte_res;
    end
    if (emit_stat) begin
      q_mem[stat_ptr] <= stat_res;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/lsbx_checker.sv
`default_nettype none

module lsbx_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic [lsbx_pkg::IN_TDATA_W-1:0]   in_tdata,
  input wire logic                              in_tlast,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [lsbx_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input wire logic [lsbx_pkg::KIND_W-1:0]       out_tuser,
  input wire logic                              out_tlast
);

  import lsbx_pkg::*;

  // the queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word valid right after reset");

  // an accepted end-of-file word always leaves a status word pending
  a_eof_status: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> out_tvalid)
    else $error("no result pending after end of file");

  // input backpressure only comes while result words wait in the queue
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with an empty result queue");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)))
    else $error("stalled result word changed");

endmodule

bind lsb_stego_bmp_extractor_core lsbx_checker u_lsbx_checker (.*);

`default_nettype wire

FILE: dv/lsbx_extract_checker.sv
`timescale 1ns / 1ps

module lsbx_extract_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [lsbx_pkg::IN_TDATA_W-1:0]  in_tdata,   // [7:0] carrier_byte
  input  logic                             in_tlast,   // end_of_file
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [lsbx_pkg::OUT_TDATA_W-1:0] out_tdata,  // [7:0] out_byte, [9:8] status
  input  logic [lsbx_pkg::KIND_W-1:0]      out_tuser,  // [1:0] kind
  input  logic                             out_tlast,  // last
  output int                               mismatches,
  output int                               results_pending
);
  import lsbx_pkg::*;

  typedef enum logic [2:0] {
    PARSE_IMAGE, PARSE_HEADER, PARSE_NAME, PARSE_DATA, PARSE_DONE, PARSE_FAILED
  } parse_phase_t;

  // payload magic, first character in the top byte
  localparam logic [31:0] PAYLOAD_TAG = 32'h45435331;

  logic [POS_W-1:0]    file_pos;
  logic [POS_W-1:0]    pix_offset;
  logic [POS_W-1:0]    name_len;
  logic [POS_W-1:0]    data_len;
  logic [POS_W-1:0]    left_to_emit;
  parse_phase_t        phase;
  logic [BYTE_W-1:0]   bit_acc;
  logic [2:0]          bit_cnt;
  logic [3:0]          hdr_idx;
  logic [STATUS_W-1:0] err_code;
  result_t             pending_recovered[$];
  int                  words_seen;

  task automatic clear_parse();
    file_pos     = '0;
    pix_offset   = '0;
    name_len     = '0;
    data_len     = '0;
    left_to_emit = '0;
    phase        = PARSE_IMAGE;
    bit_acc      = '0;
    bit_cnt      = '0;
    hdr_idx      = '0;
    err_code     = ST_OK;
  endtask

  // keep the first error, stop extracting
  task automatic flag_failure(input logic [STATUS_W-1:0] code);
    if (err_code == ST_OK) err_code = code;
    phase = PARSE_FAILED;
  endtask

  task automatic queue_result(input logic [BYTE_W-1:0] value, input logic [KIND_W-1:0] kind,
                              input logic [STATUS_W-1:0] status, input logic last);
    result_t r;
    r.out_byte = value;
    r.kind     = kind;
    r.status   = status;
    r.last     = last;
    pending_recovered.insert(pending_recovered.size(), r);
  endtask

  // advance the parse by one file byte and queue what it recovers
  task automatic decode_carrier_byte(input logic [BYTE_W-1:0] b, input logic eof);
    logic [POS_W-1:0]    pos;
    logic [POS_W-1:0]    size;
    logic [BYTE_W-1:0]   v;
    logic [3:0]          idx;
    logic [STATUS_W-1:0] st;
    pos = file_pos;
    if (file_pos != '1) file_pos = file_pos + 1'b1;

    if (phase == PARSE_IMAGE) begin
      if ((pos == 0 && b != SIG_B) || (pos == 1 && b != SIG_M)) flag_failure(ST_INVALID);
      if (pos >= OFFSET_FIELD && pos <= OFFSET_LAST)
        pix_offset = pix_offset | ({24'd0, b} << (8 * (pos - OFFSET_FIELD)));
      if (pos == OFFSET_LAST && pix_offset < MIN_OFFSET) flag_failure(ST_INVALID);
      if (phase == PARSE_IMAGE && pos >= MIN_OFFSET && pos >= pix_offset) phase = PARSE_HEADER;
    end

    if (phase == PARSE_HEADER || phase == PARSE_NAME || phase == PARSE_DATA) begin
      bit_acc = {bit_acc[6:0], b[0]};
      if (bit_cnt != 3'd7) begin
        bit_cnt = bit_cnt + 1'b1;
      end else begin
        v       = bit_acc;
        bit_cnt = '0;
        if (phase == PARSE_HEADER) begin
          idx = hdr_idx;
          if (idx < 4) begin
            if (v != PAYLOAD_TAG[31 - 8 * idx -: 8]) flag_failure(ST_NOFILE);
          end else if (idx < 8) begin
            name_len = name_len | ({24'd0, v} << (8 * (idx - 4)));
          end else if (idx <= HDR_LAST_IDX) begin
            data_len = data_len | ({24'd0, v} << (8 * (idx - 8)));
          end
          hdr_idx = idx + 1'b1;
          if (phase == PARSE_HEADER && idx == HDR_LAST_IDX) begin
            if (name_len == 0 || name_len[31] || data_len[31]) begin
              flag_failure(ST_CORRUPT);
            end else begin
              left_to_emit = name_len;
              phase        = PARSE_NAME;
            end
          end
        end else if (phase == PARSE_NAME) begin
          queue_result(v, KIND_NAME, ST_OK, 1'b0);
          left_to_emit = left_to_emit - 1'b1;
          if (left_to_emit == 0) begin
            if (data_len == 0) begin
              phase = PARSE_DONE;
            end else begin
              left_to_emit = data_len;
              phase        = PARSE_DATA;
            end
          end
        end else begin
          queue_result(v, KIND_DATA, ST_OK, 1'b0);
          left_to_emit = left_to_emit - 1'b1;
          if (left_to_emit == 0) phase = PARSE_DONE;
        end
      end
    end

    if (eof) begin
      size = file_pos;
      if (size < MIN_FILE_SIZE || err_code == ST_INVALID || pix_offset >= size)
        st = ST_INVALID;
      else if (err_code != ST_OK)
        st = err_code;
      else if (phase == PARSE_DONE)
        st = ST_OK;
      else if (phase == PARSE_NAME || phase == PARSE_DATA)
        st = ST_CORRUPT;
      else
        st = ST_NOFILE;
      queue_result('0, KIND_STATUS, st, 1'b1);
      clear_parse();
    end
  endtask

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    $display("%0t: result word %0d: %s is 0x%0h, predicted 0x%0h",
             $time, words_seen, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      clear_parse();
      pending_recovered.delete();
      mismatches = 0;
      words_seen = 0;
    end else begin
      // take the input side first so a same-edge result still finds its prediction
      if (in_tvalid && in_tready) decode_carrier_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (pending_recovered.size() == 0) begin
          report_mismatch("unpredicted word, tdata", out_tdata, 0);
        end else begin
          want = pending_recovered.pop_front();
          if (out_tdata[7:0] != want.out_byte)
            report_mismatch("out_byte", out_tdata[7:0], want.out_byte);
          if (out_tdata[9:8] != want.status)
            report_mismatch("status", out_tdata[9:8], want.status);
          if (out_tdata[15:10] != '0)
            report_mismatch("tdata padding", out_tdata[15:10], 0);
          if (out_tuser != want.kind)
            report_mismatch("kind", out_tuser, want.kind);
          if (out_tlast != want.last)
            report_mismatch("last", out_tlast, want.last);
        end
        words_seen++;
      end
    end
    results_pending = pending_recovered.size();
  end

endmodule

FILE: dv/tb_lsb_stego_bmp_extractor_core.sv
`timescale 1ns / 1ps

module tb_lsb_stego_bmp_extractor_core;
  import lsbx_pkg::*;

  localparam int          RANDOM_WORDS = 200;
  localparam int          QUIET_WORDS  = 100;   // tail of the run with no idling
  localparam logic [31:0] PAYLOAD_TAG  = 32'h45435331;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tlast   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [KIND_W-1:0]      out_tuser;
  logic                   out_tlast;

  int                     mismatches;
  int                     results_pending;
  int                     sent_words      = 0;
  bit                     sender_idles    = 1'b0;
  bit                     receiver_stalls = 1'b0;
  logic [7:0]             carrier_q[$];   // file under construction

  always #5 clk = ~clk;

  lsb_stego_bmp_extractor_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  lsbx_extract_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast),
    .mismatches      (mismatches),
    .results_pending (results_pending)
  );

  // Hold one word on the input until it is taken; sometimes idle first.
  task automatic push_word(input logic [7:0] value, input logic eof);
    if (sender_idles && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= eof;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_words++;
    @(negedge clk);
  endtask

  task automatic send_file();
    int n;
    n = carrier_q.size();
    for (int i = 0; i < n; i++) push_word(carrier_q[i], i == n - 1);
  endtask

  // Stop feeding and wait for every predicted word to come out.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    wait (results_pending == 0);
    @(negedge clk);
  endtask

  // Add one byte at the end of the file under construction.
  task automatic append_byte(input logic [7:0] value);
    carrier_q.insert(carrier_q.size(), value);
  endtask

  task automatic pad_random(input int n);
    repeat (n) append_byte(8'($urandom));
  endtask

  task automatic trim_to(input int n);
    while (carrier_q.size() > n) void'(carrier_q.pop_back());
  endtask

  // Image header with the given signature and pixel offset, padded up to the pixels.
  task automatic start_image(input logic [31:0] offset, input logic [7:0] sig0,
                             input logic [7:0] sig1);
    carrier_q.delete();
    append_byte(sig0);
    append_byte(sig1);
    pad_random(8);
    for (int i = 0; i < 4; i++) append_byte(offset[8*i +: 8]);
    while (carrier_q.size() < offset && carrier_q.size() < 256)
      append_byte(8'($urandom));
  endtask

  // Spread one byte over the low bits of eight random pixel bytes, MSB first.
  task automatic hide_byte(input logic [7:0] value);
    logic [7:0] pixel;
    for (int i = 7; i >= 0; i--) begin
      pixel    = 8'($urandom);
      pixel[0] = value[i];
      append_byte(pixel);
    end
  endtask

  task automatic hide_word(input logic [31:0] value);
    for (int i = 0; i < 4; i++) hide_byte(value[8*i +: 8]);
  endtask

  task automatic hide_header(input logic [31:0] tag, input logic [31:0] nlen,
                             input logic [31:0] dlen);
    for (int i = 3; i >= 0; i--) hide_byte(tag[8*i +: 8]);
    hide_word(nlen);
    hide_word(dlen);
  endtask

  task automatic hide_random(input int n);
    repeat (n) hide_byte(8'($urandom));
  endtask

  // Sender side: directed files, then random files, then the verdict.
  initial begin : stimulus
    int          random_goal;
    int          choice;
    int          target;
    int          pix_start;
    logic [31:0] offset;
    logic [31:0] nlen;
    logic [31:0] dlen;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;

    // smallest offset, extreme name and data bytes, file ends on its last bit
    start_image(MIN_OFFSET, SIG_B, SIG_M);
    hide_header(PAYLOAD_TAG, 1, 2);
    hide_byte(8'hFF);
    hide_byte(8'h00);
    hide_byte(8'hA5);
    send_file();

    // a file of one byte
    carrier_q.delete();
    append_byte(SIG_B);
    send_file();

    // bad second signature byte
    start_image(20, SIG_B, SIG_M ^ 8'h80);
    pad_random(40);
    send_file();

    // offset on the last byte of the offset field, below the minimum
    start_image(MIN_OFFSET - 1, SIG_B, SIG_M);
    pad_random(46);
    send_file();

    // offset equal to the file size
    start_image(60, SIG_B, SIG_M);
    send_file();

    // too short a file beats an unfinished payload header
    start_image(MIN_OFFSET, SIG_B, SIG_M);
    hide_header(PAYLOAD_TAG, 1, 1);
    trim_to(40);
    send_file();

    // wrong magic, payload header cut short, a single payload bit
    start_image(30, SIG_B, SIG_M);
    hide_header(PAYLOAD_TAG ^ 32'h1, 1, 1);
    trim_to(62);
    send_file();
    start_image(30, SIG_B, SIG_M);
    hide_header(PAYLOAD_TAG, 1, 1);
    trim_to(70);
    send_file();
    start_image(60, SIG_B, SIG_M);
    pad_random(1);
    send_file();

    // bad lengths: zero name, data with top bit
    start_image(MIN_OFFSET, SIG_B, SIG_M);
    hide_header(PAYLOAD_TAG, 0, 4);
    send_file();
    start_image(MIN_OFFSET, SIG_B, SIG_M);
    hide_header(PAYLOAD_TAG, 1, 32'hFFFF_FFFF);
    send_file();

    // file ends inside the data
    start_image(MIN_OFFSET, SIG_B, SIG_M);
    hide_header(PAYLOAD_TAG, 1, 5);
    hide_random(3);
    pad_random(5);
    send_file();

    // let everything drain before the random part
    drain_results();

    random_goal = sent_words + RANDOM_WORDS;
    while (sent_words < random_goal) begin
      if (sent_words >= random_goal - QUIET_WORDS) begin
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
      end else begin
        sender_idles    = $urandom_range(0, 3) != 0;
        receiver_stalls = $urandom_range(0, 3) != 0;
      end

      choice = $urandom_range(0, 9);
      if (choice <= 5) begin
        // well-formed file, sometimes cut, damaged or followed by spare pixels
        offset = $urandom_range(MIN_OFFSET, 64);
        nlen   = $urandom_range(1, 4);
        dlen   = $urandom_range(0, 6);
        start_image(offset, SIG_B, SIG_M);
        hide_header(PAYLOAD_TAG, nlen, dlen);
        hide_random(nlen + dlen);
        pix_start = (offset > MIN_OFFSET) ? offset : MIN_OFFSET;
        case ($urandom_range(0, 7))
          0: trim_to($urandom_range(pix_start, carrier_q.size() - 1));
          1: begin
            target            = pix_start + $urandom_range(0, 95);
            carrier_q[target] = carrier_q[target] ^ 8'h01;
          end
          2: pad_random($urandom_range(1, 30));
          default: ;
        endcase
      end else if (choice <= 7) begin
        // lengths near the rejected range
        nlen = {1'($urandom_range(0, 1)), 31'($urandom_range(0, 3))};
        dlen = {1'($urandom_range(0, 1)), 31'($urandom_range(0, 5))};
        start_image($urandom_range(MIN_OFFSET, 40), SIG_B, SIG_M);
        hide_header(PAYLOAD_TAG, nlen, dlen);
        hide_random($urandom_range(0, 6));
        pad_random($urandom_range(0, 10));
      end else if (choice == 8) begin
        // noise, sometimes behind a good signature
        carrier_q.delete();
        target = $urandom_range(1, 90);
        if ($urandom_range(0, 1) == 0) begin
          append_byte(SIG_B);
          append_byte(SIG_M);
        end
        while (carrier_q.size() < target) append_byte(8'($urandom));
        trim_to(target);
      end else begin
        // good signature, offset and size both random around each other
        start_image($urandom_range(0, 120), SIG_B, SIG_M);
        target = $urandom_range(MIN_OFFSET, 100);
        while (carrier_q.size() < target) append_byte(8'($urandom));
        trim_to(target);
      end
      send_file();

      if ($urandom_range(0, 7) == 0) drain_results();
    end

    in_tvalid <= 1'b0;
    wait (results_pending == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Result side: accept by default, stall in bursts while stalls are enabled.
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (receiver_stalls && stall_left == 0 && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 13);
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Roughly 1200 words, each at worst an idle gap plus two stalled results:
  // the watchdog timeout leaves a wide margin over that.
  initial begin : watchdog
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
